@@ rtl/aavg_pkg.sv @@
// ----------------------------------------------------------------------------
// aavg_pkg - shared types and constants for the discard-and-average block
// Field widths, register map codes and the control state encoding.
// ----------------------------------------------------------------------------
`default_nettype none

package aavg_pkg;

  localparam int SAMPLE_W   = 10;  // converter sample and average fields
  localparam int CFG_W      = 8;   // avg_count / discard_count registers
  localparam int IDX_W      = 9;   // sample index within a measurement
  // Sum of kept samples. Register changes between samples can stretch a
  // measurement to about 510 kept samples, so one bit above 18 is kept.
  localparam int SUM_W      = 19;
  localparam int DIVIDEND_W = SUM_W + 1;  // sum plus rounding term
  localparam int STEP_W     = 5;          // divide step counter
  localparam int ADDR_W     = 3;          // byte address of two 32-bit regs
  localparam int DATA_W     = 32;

  // Register index, taken from paddr[2]
  localparam logic REG_AVG_COUNT     = 1'b0;
  localparam logic REG_DISCARD_COUNT = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DIV  = 3'b010,
    ST_DONE = 3'b100
  } aavg_state_e;

endpackage : aavg_pkg

`default_nettype wire

@@ rtl/aavg_div.sv @@
// ----------------------------------------------------------------------------
// aavg_div - bit-serial restoring divider
// One quotient bit per cycle through a single narrow subtractor.
// ----------------------------------------------------------------------------
`default_nettype none

module aavg_div (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            start_i,
  input  wire logic [aavg_pkg::DIVIDEND_W-1:0] dividend_i,
  input  wire logic [aavg_pkg::CFG_W-1:0]      divisor_i,
  output logic                                 done_o,
  output logic [aavg_pkg::DIVIDEND_W-1:0]      quotient_o
);
  import aavg_pkg::*;

  localparam logic [STEP_W-1:0] LastStep = STEP_W'(DIVIDEND_W - 1);

  logic                  busy_q, busy_d;
  logic                  done_q, done_d;
  logic [STEP_W-1:0]     step_q, step_d;
  logic [CFG_W-1:0]      rem_q, rem_d;
  logic [CFG_W-1:0]      dvs_q, dvs_d;
  logic [DIVIDEND_W-1:0] quo_q, quo_d;

  logic [CFG_W:0]        shifted;
  logic [CFG_W+1:0]      diff;
  logic                  fits;

  // remainder always stays below the divisor, so CFG_W bits hold it
  assign shifted = {rem_q, quo_q[DIVIDEND_W-1]};
  assign diff    = {1'b0, shifted} - {2'b00, dvs_q};
  assign fits    = ~diff[CFG_W+1];

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    step_d = step_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    quo_d  = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      step_d = '0;
      rem_d  = '0;
      dvs_d  = divisor_i;
      quo_d  = dividend_i;
    end else if (busy_q) begin
      rem_d  = fits ? diff[CFG_W-1:0] : shifted[CFG_W-1:0];
      quo_d  = {quo_q[DIVIDEND_W-2:0], fits};
      step_d = step_q + 1'b1;
      if (step_q == LastStep) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvs_q <= dvs_d;
    quo_q <= quo_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule : aavg_div

`default_nettype wire

@@ rtl/adc_discard_and_average.sv @@
// ----------------------------------------------------------------------------
// adc_discard_and_average - block-averaging decimator with rounding
// Drops leading samples of a measurement, averages the next ones, emits one
// rounded and clamped mean per completed measurement.
// ----------------------------------------------------------------------------
// A sample with start_measurement set opens a measurement and is its first
// sample. The first discard_count samples are dropped, the next avg_count
// samples are summed, and after the last one a single average transfer is
// produced: (sum + count/2) / count, clamped to 2^ADC_BITS - 1 and cut to the
// 10-bit field. An avg_count of zero counts as one. Samples that arrive while
// no measurement is open are taken and ignored. Samples are taken with no
// stall while no average is under way. The closing sample starts a
// bit-serial divide through one shared subtractor, one quotient bit per
// cycle over 20 bits; the input stays stalled after it until the average is
// loaded, later if the previous average still waits on the output register.
// A pending average does not block samples that close no measurement.
// Registers sit at byte 0 (avg_count) and byte 4 (discard_count) and may be
// written between samples; the values current at each sample are used.
// ----------------------------------------------------------------------------
`default_nettype none

module adc_discard_and_average #(
  parameter int ADC_BITS = 10
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // sample channel
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [aavg_pkg::SAMPLE_W-1:0] adc_sample_i,
  input  wire logic                          start_measurement_i,
  // average channel
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic [aavg_pkg::SAMPLE_W-1:0]      average_o,
  // configuration port
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [aavg_pkg::ADDR_W-1:0]   paddr,
  input  wire logic [aavg_pkg::DATA_W-1:0]   pwdata,
  output logic [aavg_pkg::DATA_W-1:0]        prdata,
  output logic                               pready
);
  import aavg_pkg::*;

  // converter maximum, one bit wider than the quotient for the compare
  localparam logic [DIVIDEND_W:0] MaxVal = (DIVIDEND_W+1)'((64'd1 << ADC_BITS) - 64'd1);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [CFG_W-1:0] avg_count_q, discard_count_q;
  logic             cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      avg_count_q     <= CFG_W'(1);
      discard_count_q <= '0;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_AVG_COUNT) begin
        avg_count_q <= pwdata[CFG_W-1:0];
      end else begin
        discard_count_q <= pwdata[CFG_W-1:0];
      end
    end
  end

  always_comb begin
    prdata = '0;
    case (paddr[2])
      REG_AVG_COUNT:     prdata[CFG_W-1:0] = avg_count_q;
      REG_DISCARD_COUNT: prdata[CFG_W-1:0] = discard_count_q;
      default:           prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Measurement tracking
  // --------------------------------------------------------------------------
  aavg_state_e state_q, state_d;

  logic                  measuring_q, measuring_d;
  logic [IDX_W-1:0]      idx_q, idx_d;
  logic [SUM_W-1:0]      sum_q, sum_d;

  logic                  in_xfer;
  logic [CFG_W-1:0]      count;
  logic                  div_start;
  logic [DIVIDEND_W-1:0] dividend;

  logic                  div_done;
  logic [DIVIDEND_W-1:0] quotient;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_xfer    = in_valid_i & ~in_stall_o;
  assign count      = (avg_count_q == '0) ? CFG_W'(1) : avg_count_q;

  always_comb begin
    logic             meas;
    logic [IDX_W-1:0] idx_base;
    logic [IDX_W-1:0] idx_inc;
    logic [IDX_W-1:0] thr;
    logic [SUM_W-1:0] sum_base;
    logic [SUM_W-1:0] sum_new;

    meas     = start_measurement_i | measuring_q;
    idx_base = start_measurement_i ? '0 : idx_q;
    sum_base = start_measurement_i ? '0 : sum_q;
    idx_inc  = idx_base + 1'b1;
    thr      = {1'b0, discard_count_q} + {1'b0, count};
    sum_new  = sum_base + SUM_W'(adc_sample_i);
    dividend = DIVIDEND_W'(sum_new) + DIVIDEND_W'(count[CFG_W-1:1]);

    measuring_d = measuring_q;
    idx_d       = idx_q;
    sum_d       = sum_q;
    div_start   = 1'b0;

    if (in_xfer && meas) begin
      measuring_d = 1'b1;
      if (idx_base < {1'b0, discard_count_q}) begin
        // still in the discard phase
        idx_d = idx_inc;
        sum_d = sum_base;
      end else if (idx_inc < thr) begin
        idx_d = idx_inc;
        sum_d = sum_new;
      end else begin
        // last kept sample: hand the rounded sum to the divider
        measuring_d = 1'b0;
        idx_d       = '0;
        sum_d       = '0;
        div_start   = 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer and output register
  // --------------------------------------------------------------------------
  logic                  out_valid_q, out_valid_d;
  logic [SAMPLE_W-1:0]   average_q, average_d;
  logic                  out_free;
  logic [DIVIDEND_W-1:0] clamped;

  assign out_free = ~out_valid_q | ~out_stall_i;
  assign clamped  = ({1'b0, quotient} > MaxVal) ? MaxVal[DIVIDEND_W-1:0] : quotient;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q & out_stall_i;
    average_d   = average_q;
    case (state_q)
      ST_IDLE: begin
        if (div_start) state_d = ST_DIV;
      end
      ST_DIV: begin
        if (div_done) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          average_d   = clamped[SAMPLE_W-1:0];
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      measuring_q <= 1'b0;
      idx_q       <= '0;
      sum_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      measuring_q <= measuring_d;
      idx_q       <= idx_d;
      sum_q       <= sum_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    average_q <= average_d;
  end

  assign out_valid_o = out_valid_q;
  assign average_o   = average_q;

  // --------------------------------------------------------------------------
  // Shared divide unit
  // --------------------------------------------------------------------------
  aavg_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (dividend),
    .divisor_i  (count),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

endmodule : adc_discard_and_average

`default_nettype wire

@@ tb/tb_adc_discard_and_average.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_adc_discard_and_average - self-checking bench for the averaging decimator
// Feeds measurement sequences of converter samples, predicts every rounded and
// clamped average in step with the accepted samples, and checks each average
// transfer in order. Registers are changed over APB between phases.
// ----------------------------------------------------------------------------

module tb_adc_discard_and_average;
  import aavg_pkg::*;

  localparam int ADC_BITS      = 10;
  localparam int ADC_MAX       = (1 << ADC_BITS) - 1;
  localparam int SETTLE_CYCLES = 40;  // covers the serial divide and the output register

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic                start;
  } sample_item_t;

  // DUT signals
  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_stall_o;
  logic [SAMPLE_W-1:0] adc_sample_i;
  logic                start_measurement_i;
  logic                out_valid_o;
  logic                out_stall_i;
  logic [SAMPLE_W-1:0] average_o;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ADDR_W-1:0]   paddr;
  logic [DATA_W-1:0]   pwdata;
  logic [DATA_W-1:0]   prdata;
  logic                pready;

  // Stimulus and expectations
  sample_item_t        sample_queue[$];
  logic [SAMPLE_W-1:0] expected_avg[$];

  // Predictor copy of the block: registers and measurement state
  logic [CFG_W-1:0] cfg_avg;
  logic [CFG_W-1:0] cfg_discard;
  logic             meas_open;
  logic [IDX_W-1:0] meas_idx;
  int unsigned      meas_sum;

  int  sample_xfers;       // bumped on every accepted sample (posedge side)
  int  sample_xfers_used;  // what the driver has already acted on
  int  averages_seen;
  int  mismatches;
  int  in_gap;
  int  out_gap;
  bit  no_idle;

  adc_discard_and_average #(
    .ADC_BITS(ADC_BITS)
  ) u_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .adc_sample_i       (adc_sample_i),
    .start_measurement_i(start_measurement_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .average_o          (average_o),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready)
  );

  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("MISMATCH %s: got %0d, expected %0d", what, got, want);
    mismatches++;
  endtask

  // Advances the predicted measurement by one accepted sample. A start
  // reopens counting even mid-measurement; samples while idle do nothing.
  function automatic void average_step(input logic [SAMPLE_W-1:0] sample, input logic start);
    int unsigned count;
    int unsigned mean;
    count = (cfg_avg == 0) ? 1 : cfg_avg;
    if (start) begin
      meas_open = 1'b1;
      meas_idx  = '0;
      meas_sum  = 0;
    end
    if (!meas_open) return;
    if (meas_idx < cfg_discard) begin
      meas_idx = meas_idx + 1'b1;
      return;
    end
    meas_sum = meas_sum + sample;
    meas_idx = meas_idx + 1'b1;
    // index may already be past the end if registers shrank mid-measurement
    if (meas_idx < cfg_discard + count) return;
    mean = (meas_sum + count / 2) / count;
    if (mean > ADC_MAX) mean = ADC_MAX;
    expected_avg.push_back(mean[SAMPLE_W-1:0]);
    meas_open = 1'b0;
    meas_idx  = '0;
    meas_sum  = 0;
  endfunction

  // Sample side: acceptance seen at the rising edge feeds the predictor
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) begin
      average_step(adc_sample_i, start_measurement_i);
      sample_xfers++;
    end
  end

  // Average side: compare each transfer with the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      averages_seen++;
      if (expected_avg.size() == 0) begin
        report_mismatch("unexpected average", average_o, -1);
      end else begin
        if (average_o !== expected_avg[0])
          report_mismatch("average", average_o, expected_avg[0]);
        void'(expected_avg.pop_front());
      end
    end
  end

  // Driver: moves the sample channel and the output stall at the falling edge.
  // A payload is held until its transfer; idle gaps are inserted at random.
  always @(negedge clk_i) begin
    sample_item_t item;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || sample_xfers != sample_xfers_used) begin
      if (sample_xfers != sample_xfers_used && !no_idle && $urandom_range(0, 7) == 0)
        in_gap = $urandom_range(1, 9);
      sample_xfers_used = sample_xfers;
      if (in_gap > 0) begin
        in_gap--;
        in_valid_i <= 1'b0;
      end else if (sample_queue.size() > 0) begin
        item = sample_queue.pop_front();
        in_valid_i          <= 1'b1;
        adc_sample_i        <= item.sample;
        start_measurement_i <= item.start;
      end else begin
        in_valid_i <= 1'b0;
      end
    end

    if (out_gap > 0) begin
      out_gap--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
      if (!no_idle && $urandom_range(0, 5) == 0) out_gap = $urandom_range(1, 9);
    end
  end

  function automatic void push_sample(input int sample, input logic start);
    sample_item_t item;
    item.sample = sample[SAMPLE_W-1:0];
    item.start  = start;
    sample_queue.push_back(item);
  endfunction

  // Biased toward the field extremes
  function automatic int rand_sample();
    case ($urandom_range(0, 3))
      0:       return 0;
      1:       return ADC_MAX;
      default: return $urandom_range(0, ADC_MAX);
    endcase
  endfunction

  // Register write over APB followed by a readback of the same register
  task automatic cfg_write(input logic sel, input logic [CFG_W-1:0] value);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {sel, 2'b00};
    pwdata  <= {{(DATA_W-CFG_W){1'b0}}, value};
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (sel == REG_AVG_COUNT) cfg_avg = value;
    else cfg_discard = value;
    @(negedge clk_i);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata[CFG_W-1:0] !== value)
      report_mismatch(sel == REG_AVG_COUNT ? "avg_count readback" : "discard_count readback",
                      prdata[CFG_W-1:0], value);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Block is idle once everything queued went in and every average came out
  task automatic wait_idle();
    do @(posedge clk_i);
    while (sample_queue.size() != 0 || in_valid_i || expected_avg.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Random measurements under the current registers: mostly complete ones,
  // some cut short (the next start abandons them), some stray samples.
  task automatic queue_random_sequences(input int seqs, inout int useful);
    int span;
    int len;
    int kind;
    for (int k = 0; k < seqs; k++) begin
      span = cfg_discard + ((cfg_avg == 0) ? 1 : cfg_avg);
      kind = $urandom_range(0, 19);
      if (kind < 14) len = span;
      else if (kind < 17) len = $urandom_range(1, span);
      else len = 0;
      if (len > 0) begin
        push_sample(rand_sample(), 1'b1);
        for (int j = 1; j < len; j++) push_sample(rand_sample(), 1'b0);
        useful += len;
      end else begin
        repeat ($urandom_range(1, 3)) push_sample(rand_sample(), 1'b0);
      end
    end
  endtask

  initial begin
    int useful;
    int phase;
    useful              = 0;
    mismatches          = 0;
    averages_seen       = 0;
    sample_xfers        = 0;
    sample_xfers_used   = 0;
    in_gap              = 0;
    out_gap             = 0;
    no_idle             = 1'b0;
    cfg_avg             = 8'd1;  // register reset values
    cfg_discard         = 8'd0;
    meas_open           = 1'b0;
    meas_idx            = '0;
    meas_sum            = 0;
    rst_ni              = 1'b0;
    in_valid_i          = 1'b0;
    adc_sample_i        = '0;
    start_measurement_i = 1'b0;
    out_stall_i         = 1'b0;
    psel                = 1'b0;
    penable             = 1'b0;
    pwrite              = 1'b0;
    paddr               = '0;
    pwdata              = '0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Reset registers: one sample per measurement; idle samples are dropped
    push_sample(ADC_MAX, 1'b0);
    push_sample(0, 1'b1);
    push_sample(ADC_MAX, 1'b1);
    push_sample(5, 1'b0);
    wait_idle();

    // Zero average count behaves as one
    cfg_write(REG_AVG_COUNT, 8'd0);
    push_sample(512, 1'b1);
    wait_idle();

    // Discard one, average two: rounding up, then a restart mid-measurement
    cfg_write(REG_AVG_COUNT, 8'd2);
    cfg_write(REG_DISCARD_COUNT, 8'd1);
    push_sample(1000, 1'b1);
    push_sample(1, 1'b0);
    push_sample(2, 1'b0);
    push_sample(7, 1'b1);
    push_sample(8, 1'b0);
    push_sample(9, 1'b1);
    push_sample(ADC_MAX, 1'b0);
    push_sample(ADC_MAX - 1, 1'b0);
    wait_idle();

    // Count shrunk under an open measurement: the next kept sample closes it
    // with four full-scale samples over a count of one, so the mean clamps.
    cfg_write(REG_AVG_COUNT, 8'd4);
    cfg_write(REG_DISCARD_COUNT, 8'd0);
    push_sample(ADC_MAX, 1'b1);
    push_sample(ADC_MAX, 1'b0);
    push_sample(ADC_MAX, 1'b0);
    wait_idle();
    cfg_write(REG_AVG_COUNT, 8'd1);
    push_sample(ADC_MAX, 1'b0);
    wait_idle();

    // Random phases, mostly small sizes; one phase at the register maxima
    phase = 0;
    while (phase <= 3 || useful < 580 || averages_seen < 20) begin
      if (phase == 3) begin
        cfg_write(REG_AVG_COUNT, 8'd255);
        cfg_write(REG_DISCARD_COUNT, 8'd255);
        push_sample(rand_sample(), 1'b1);
        for (int j = 1; j < 510; j++)
          push_sample(($urandom_range(0, 3) != 0) ? ADC_MAX : rand_sample(), 1'b0);
        useful += 510;
      end else begin
        cfg_write(REG_AVG_COUNT,
                  ($urandom_range(0, 9) == 0) ? 8'd0 : 8'($urandom_range(1, 5)));
        cfg_write(REG_DISCARD_COUNT,
                  ($urandom_range(0, 2) == 0) ? 8'd0 : 8'($urandom_range(1, 4)));
        queue_random_sequences($urandom_range(4, 10), useful);
      end
      wait_idle();
      phase++;
    end

    // Closing stretch at full rate on both sides
    no_idle = 1'b1;
    cfg_write(REG_AVG_COUNT, 8'($urandom_range(1, 4)));
    cfg_write(REG_DISCARD_COUNT, 8'($urandom_range(0, 3)));
    queue_random_sequences(10, useful);
    wait_idle();

    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Watchdog, far above the slowest legal run
  initial begin
    #5ms;
    $display("TEST FAILED");
    $finish;
  end

endmodule

@@ adc_discard_and_average.f @@
rtl/aavg_pkg.sv
rtl/aavg_div.sv
rtl/adc_discard_and_average.sv
tb/tb_adc_discard_and_average.sv
